FILE: design/ezq_pkg.sv
// Package for the Euler-angle to quaternion converter.
// Holds fixed-point constants, the series coefficient tables and a rounding helper.
// No dependencies.
package ezq_pkg;

	localparam logic [26:0] DEG2RAD = 27'd74961321;
	localparam int SIN_STEPS = 5;
	localparam int COS_STEPS = 6;
	localparam int RED_STAGES = 2;
	localparam logic [31:0] MOD_RECIP = 32'd95443717;

	function automatic logic [7:0] sin_n(input int idx);
		logic [7:0] n;
		case (idx)
			0: n = 8'd110;
			1: n = 8'd72;
			2: n = 8'd42;
			3: n = 8'd20;
			4: n = 8'd6;
			default: n = 8'd6;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] cos_n(input int idx);
		logic [7:0] n;
		case (idx)
			0: n = 8'd132;
			1: n = 8'd90;
			2: n = 8'd56;
			3: n = 8'd30;
			4: n = 8'd12;
			5: n = 8'd2;
			default: n = 8'd2;
		endcase
		return n;
	endfunction

	function automatic logic signed [31:0] rnd30(input logic signed [63:0] p);
		logic [63:0] mag;
		logic [63:0] r;
		mag = p[63] ? 64'(-p) : 64'(p);
		r = (mag + (64'd1 << 29)) >> 30;
		return p[63] ? signed'(32'(-r)) : signed'(r[31:0]);
	endfunction

endpackage

FILE: design/ezq_dly.sv
// Fixed-length delay line with a shared advance enable.
// Used to align side data with the arithmetic pipelines. No dependencies.
module ezq_dly #(
	parameter int W = 8,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] tap_q [D];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= din;
			for (int i = 1; i < D; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign dout = tap_q[D-1];

endmodule

FILE: design/ezq_hstep.sv
// One three-stage Horner step of the sine/cosine series: t' = 1 - rdiv(x2 * t, N).
// Division by the constant N uses a reciprocal product with one correction.
// Depends on nothing but its parameter.
module ezq_hstep #(
	parameter logic [7:0] N = 8'd6
) (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        x2_in,
	input  logic [30:0]        t_in,
	output logic [31:0]        x2_out,
	output logic signed [31:0] t_out
);

	localparam logic [63:0] NHALF = 64'(N) << 29;
	localparam logic [33:0] RECIP = 34'((64'd1 << 33) / 64'(N));

	logic [62:0]        p_s1;
	logic [31:0]        x2_s1;
	logic [32:0]        v_s2;
	logic [32:0]        q0_s2;
	logic [31:0]        x2_s2;
	logic signed [31:0] t_s3;
	logic [31:0]        x2_s3;
	logic [32:0]        v_c;
	logic [66:0]        qp_c;
	logic [40:0]        rem_c;
	logic [32:0]        q_c;
	logic [33:0]        t_c;

	always_comb begin
		v_c = 33'((64'(p_s1) + NHALF) >> 30);
		qp_c = 67'(v_c) * 67'(RECIP);
		rem_c = 41'(v_s2) - 41'(q0_s2) * 41'(N);
		q_c = q0_s2 + ((rem_c >= 41'(N)) ? 33'd1 : 33'd0);
		t_c = (34'd1 << 30) - 34'(q_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= 63'(64'(x2_in) * 64'(t_in));
			x2_s1 <= x2_in;
			v_s2 <= v_c;
			q0_s2 <= qp_c[65:33];
			x2_s2 <= x2_s1;
			t_s3 <= signed'(t_c[31:0]);
			x2_s3 <= x2_s2;
		end
	end

	assign t_out = t_s3;
	assign x2_out = x2_s3;

endmodule

FILE: design/ezq_lane.sv
// One angle lane: modulo-360 reduction, degree-to-radian scaling and the
// half-angle sine/cosine series. Depends on ezq_pkg, ezq_hstep and ezq_dly.
module ezq_lane #(
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] angle,
	output logic signed [31:0] cos_h,
	output logic signed [31:0] sin_h
);

	localparam logic [63:0] MOD = 64'd360 << ANGLE_FRAC_BITS;
	localparam int SHR = ANGLE_FRAC_BITS + 3;
	localparam logic [63:0] OFS = (MOD - ((64'd1 << 31) % MOD)) % MOD;
	localparam logic [63:0] MODH = MOD >> 1;
	localparam logic [63:0] XRND = 64'd1 << (ANGLE_FRAC_BITS + 2);

	logic [31:0]        u_q;
	logic [31:0]        u1_q;
	logic [31:0]        q0_q;
	logic [33:0]        rem_q;
	logic [33:0]        rr_q;
	logic [31:0]        mag_q;
	logic               neg_q;
	logic [30:0]        x_q;
	logic               negc_q;
	logic [31:0]        x2_q;
	logic [30:0]        xd_q;
	logic               negd_q;
	logic [31:0]        xdl;
	logic [61:0]        sp_q;
	logic               negs_q;
	logic signed [31:0] s_q;
	logic signed [31:0] c_q;
	logic [63:0]        qp_c;
	logic [63:0]        rem0_c;
	logic [33:0]        sum_c;
	logic [33:0]        rr_c;
	logic               neg_c;
	logic [63:0]        xp_c;
	logic [63:0]        xx_c;
	logic [63:0]        sr_c;
	logic [31:0]        sm_c;

	logic signed [31:0] st [ezq_pkg::SIN_STEPS+1];
	logic [31:0]        sx2 [ezq_pkg::SIN_STEPS];
	logic signed [31:0] ct [ezq_pkg::COS_STEPS+1];
	logic [31:0]        cx2 [ezq_pkg::COS_STEPS];

	always_comb begin
		qp_c = (64'(u_q) >> SHR) * 64'(ezq_pkg::MOD_RECIP);
		rem0_c = 64'(u1_q) - 64'(q0_q) * MOD;
		sum_c = rem_q + OFS[33:0];
		rr_c = (sum_c >= MOD[33:0]) ? sum_c - MOD[33:0] : sum_c;
		neg_c = rr_q >= MODH[33:0];
		xp_c = 64'(mag_q) * 64'(ezq_pkg::DEG2RAD) + XRND;
		xx_c = 64'(x_q) * 64'(x_q) + (64'd1 << 29);
		sr_c = (64'(sp_q) + (64'd1 << 29)) >> 30;
		sm_c = (sr_c > (64'd1 << 30)) ? (32'd1 << 30) : sr_c[31:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_q <= {~angle[31], angle[30:0]};
			u1_q <= u_q;
			q0_q <= qp_c[63:32];
			rem_q <= (rem0_c >= MOD) ? 34'(rem0_c - MOD) : rem0_c[33:0];
			rr_q <= rr_c;
			neg_q <= neg_c;
			mag_q <= neg_c ? 32'(MOD[33:0] - rr_q) : rr_q[31:0];
			x_q <= 31'(xp_c >> (ANGLE_FRAC_BITS + 3));
			negc_q <= neg_q;
			x2_q <= xx_c[61:30];
			xd_q <= x_q;
			negd_q <= negc_q;
			sp_q <= 62'(64'(xdl[30:0]) * 64'(st[ezq_pkg::SIN_STEPS][30:0]));
			negs_q <= xdl[31];
			s_q <= negs_q ? -signed'(sm_c) : signed'(sm_c);
			if (ct[ezq_pkg::COS_STEPS] < 0) begin
				c_q <= '0;
			end else if (ct[ezq_pkg::COS_STEPS] > (32'sd1 <<< 30)) begin
				c_q <= 32'sd1 <<< 30;
			end else begin
				c_q <= ct[ezq_pkg::COS_STEPS];
			end
		end
	end

	ezq_dly #(.W(32), .D(3 * ezq_pkg::SIN_STEPS)) u_xdly (
		.clk  (clk),
		.en   (en),
		.din  ({negd_q, xd_q}),
		.dout (xdl)
	);

	assign st[0] = 32'sd1 <<< 30;
	assign sx2[0] = x2_q;
	for (genvar si = 0; si < ezq_pkg::SIN_STEPS; si++) begin : g_sin
		if (si < ezq_pkg::SIN_STEPS - 1) begin : g_mid
			ezq_hstep #(.N(ezq_pkg::sin_n(si))) u_step (
				.clk    (clk),
				.en     (en),
				.x2_in  (sx2[si]),
				.t_in   (st[si][30:0]),
				.x2_out (sx2[si+1]),
				.t_out  (st[si+1])
			);
		end else begin : g_end
			ezq_hstep #(.N(ezq_pkg::sin_n(si))) u_step (
				.clk    (clk),
				.en     (en),
				.x2_in  (sx2[si]),
				.t_in   (st[si][30:0]),
				.x2_out (),
				.t_out  (st[si+1])
			);
		end
	end

	assign ct[0] = 32'sd1 <<< 30;
	assign cx2[0] = x2_q;
	for (genvar ci = 0; ci < ezq_pkg::COS_STEPS; ci++) begin : g_cos
		if (ci < ezq_pkg::COS_STEPS - 1) begin : g_mid
			ezq_hstep #(.N(ezq_pkg::cos_n(ci))) u_step (
				.clk    (clk),
				.en     (en),
				.x2_in  (cx2[ci]),
				.t_in   (ct[ci][30:0]),
				.x2_out (cx2[ci+1]),
				.t_out  (ct[ci+1])
			);
		end else begin : g_end
			ezq_hstep #(.N(ezq_pkg::cos_n(ci))) u_step (
				.clk    (clk),
				.en     (en),
				.x2_in  (cx2[ci]),
				.t_in   (ct[ci][30:0]),
				.x2_out (),
				.t_out  (ct[ci+1])
			);
		end
	end

	ezq_dly #(.W(32), .D(2)) u_sdly (
		.clk  (clk),
		.en   (en),
		.din  (s_q),
		.dout (sin_h)
	);

	assign cos_h = c_q;

endmodule

FILE: design/ezq_merge.sv
// Combines the three lanes' half-angle sines and cosines into w, x, y, z
// through products of three and rounds to the output format. Depends on ezq_pkg, ezq_dly.
module ezq_merge #(
	parameter int OUT_FRAC_BITS = 14
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] cp,
	input  logic signed [31:0] sp,
	input  logic signed [31:0] cy,
	input  logic signed [31:0] sy,
	input  logic signed [31:0] cr,
	input  logic signed [31:0] sr,
	output logic [15:0]        quat_w,
	output logic [15:0]        quat_x,
	output logic [15:0]        quat_y,
	output logic [15:0]        quat_z
);

	localparam int SH = 30 - OUT_FRAC_BITS;
	localparam logic [33:0] HALF = (SH > 0) ? (34'd1 << ((SH > 0) ? SH - 1 : 0)) : 34'd0;
	localparam logic [33:0] LIM = 34'd1 << OUT_FRAC_BITS;
	localparam logic [33:0] PMAX = (LIM < 34'd32767) ? LIM : 34'd32767;
	localparam logic [33:0] NMAX = (LIM < 34'd32768) ? LIM : 34'd32768;

	logic signed [63:0] a_s1 [4];
	logic signed [31:0] b_s2 [4];
	logic signed [63:0] p_s3 [8];
	logic signed [32:0] q_s4 [4];
	logic [63:0]        cys_dl;

	function automatic logic [15:0] to_out(input logic signed [32:0] v);
		logic [33:0] mag;
		logic [33:0] rm;
		mag = v[32] ? 34'(-v) : 34'(v);
		rm = (mag + HALF) >> SH;
		if (!v[32] && rm > PMAX) begin
			rm = PMAX;
		end
		if (v[32] && rm > NMAX) begin
			rm = NMAX;
		end
		return v[32] ? 16'(-rm) : rm[15:0];
	endfunction

	ezq_dly #(.W(64), .D(2)) u_ydly (
		.clk  (clk),
		.en   (en),
		.din  ({sy, cy}),
		.dout (cys_dl)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1[0] <= 64'(cr) * 64'(cp);
			a_s1[1] <= 64'(sr) * 64'(sp);
			a_s1[2] <= 64'(sr) * 64'(cp);
			a_s1[3] <= 64'(cr) * 64'(sp);
			for (int i = 0; i < 4; i++) begin
				b_s2[i] <= ezq_pkg::rnd30(a_s1[i]);
			end
			p_s3[0] <= 64'(b_s2[0]) * 64'(signed'(cys_dl[31:0]));
			p_s3[1] <= 64'(b_s2[1]) * 64'(signed'(cys_dl[63:32]));
			p_s3[2] <= 64'(b_s2[2]) * 64'(signed'(cys_dl[31:0]));
			p_s3[3] <= 64'(b_s2[3]) * 64'(signed'(cys_dl[63:32]));
			p_s3[4] <= 64'(b_s2[3]) * 64'(signed'(cys_dl[31:0]));
			p_s3[5] <= 64'(b_s2[2]) * 64'(signed'(cys_dl[63:32]));
			p_s3[6] <= 64'(b_s2[0]) * 64'(signed'(cys_dl[63:32]));
			p_s3[7] <= 64'(b_s2[1]) * 64'(signed'(cys_dl[31:0]));
			q_s4[0] <= 33'(ezq_pkg::rnd30(p_s3[0])) + 33'(ezq_pkg::rnd30(p_s3[1]));
			q_s4[1] <= 33'(ezq_pkg::rnd30(p_s3[2])) - 33'(ezq_pkg::rnd30(p_s3[3]));
			q_s4[2] <= 33'(ezq_pkg::rnd30(p_s3[4])) + 33'(ezq_pkg::rnd30(p_s3[5]));
			q_s4[3] <= 33'(ezq_pkg::rnd30(p_s3[6])) - 33'(ezq_pkg::rnd30(p_s3[7]));
		end
	end

	assign quat_w = to_out(q_s4[0]);
	assign quat_x = to_out(q_s4[1]);
	assign quat_y = to_out(q_s4[2]);
	assign quat_z = to_out(q_s4[3]);

endmodule

FILE: design/euler_to_quaternion_core.sv
// Top level of the Euler-angle to unit-quaternion converter.
// Three angle lanes feed one merge stage. Depends on ezq_pkg, ezq_lane, ezq_merge.
//
// Channel   Dir  Fields (lowest bit first)
// s_*       in   tdata: pitch_deg[31:0], yaw_deg[63:32], roll_deg[95:64]
// m_*       out  tdata: quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
//
// One transaction is accepted per cycle unless the pipeline holds (s_tready low). An
// accepted transaction passes through the modulo-360 reduction by reciprocal product,
// the Horner chains of the sine and cosine series, the merge stage and the output register.
// Reset clears only the valid flags. The whole pipeline holds when its last stage has a
// transaction and the output register is full and not being read.
module euler_to_quaternion_core #(
	parameter int ANGLE_FRAC_BITS = 16,
	parameter int OUT_FRAC_BITS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // pitch_deg, yaw_deg, roll_deg
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // quat_w, quat_x, quat_y, quat_z
);

	localparam int LANE_LAT = ezq_pkg::RED_STAGES + 24;
	localparam int VL = LANE_LAT + 4;

	logic [VL-1:0]      vld_q;
	logic               out_vld_q;
	logic [63:0]        out_q;
	logic               adv;
	logic               ld;
	logic signed [31:0] cos_h [3];
	logic signed [31:0] sin_h [3];
	logic [15:0]        qw;
	logic [15:0]        qx;
	logic [15:0]        qy;
	logic [15:0]        qz;

	assign adv = !(vld_q[VL-1] && out_vld_q && !m_tready);
	assign ld = vld_q[VL-1] && (!out_vld_q || m_tready);
	assign s_tready = adv;

	for (genvar li = 0; li < 3; li++) begin : g_lane
		ezq_lane #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane (
			.clk   (clk),
			.en    (adv),
			.angle (signed'(s_tdata[32*li +: 32])),
			.cos_h (cos_h[li]),
			.sin_h (sin_h[li])
		);
	end

	ezq_merge #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_merge (
		.clk    (clk),
		.en     (adv),
		.cp     (cos_h[0]),
		.sp     (sin_h[0]),
		.cy     (cos_h[1]),
		.sy     (sin_h[1]),
		.cr     (cos_h[2]),
		.sr     (sin_h[2]),
		.quat_w (qw),
		.quat_x (qx),
		.quat_y (qy),
		.quat_z (qz)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (adv) begin
				vld_q <= {vld_q[VL-2:0], s_tvalid};
			end
			if (ld) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			out_q <= {qz, qy, qx, qw};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = out_q;

endmodule
